[hdl/running_mean_variance_min_max_macros.svh]
// Assertion macros shared by the running statistics block.
`ifndef RUNNING_MEAN_VARIANCE_MIN_MAX_MACROS_SVH
`define RUNNING_MEAN_VARIANCE_MIN_MAX_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMV_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("running statistics: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RMV_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("running statistics: next-cycle check failed");

`endif

[hdl/rmvmm_pkg.sv]
// Shared constants for the running statistics block.
`timescale 1ns / 1ps
package rmvmm_pkg;
	localparam int MEAN_EXTRA = 16;
	localparam int MEAN_HALF  = 1 << (MEAN_EXTRA - 1);
	localparam int DIV_W      = 64;
	localparam int IT_W       = $clog2(DIV_W);
endpackage

[hdl/rmvmm_if.sv]
// Valid/ready channel interfaces for samples and statistics.
`timescale 1ns / 1ps
interface rmvmm_in_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          new_stream;
	modport source(output valid, sample, new_stream, input ready);
	modport sink(input valid, sample, new_stream, output ready);
endinterface

interface rmvmm_out_if #(parameter int SAMPLE_BITS = 24, parameter int COUNT_BITS = 32);
	logic                            valid;
	logic                            ready;
	logic [COUNT_BITS-1:0]           sample_count;
	logic signed [SAMPLE_BITS-1:0]   mean_value;
	logic [2*SAMPLE_BITS-1:0]        variance;
	logic [SAMPLE_BITS-1:0]          std_deviation;
	logic signed [SAMPLE_BITS-1:0]   minimum;
	logic signed [SAMPLE_BITS-1:0]   maximum;
	logic                            count_saturated;
	modport source(output valid, sample_count, mean_value, variance, std_deviation,
		minimum, maximum, count_saturated, input ready);
	modport sink(input valid, sample_count, mean_value, variance, std_deviation,
		minimum, maximum, count_saturated, output ready);
endinterface

[hdl/rmvmm_alu.sv]
// Shared compare/subtract unit used by the divider and square root steps.
`timescale 1ns / 1ps
module rmvmm_alu #(
	parameter int W = 34
) (
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] diff,
	output logic         ge
);
	logic [W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[W-1:0];
	assign ge   = ~full[W];
endmodule

[hdl/running_mean_variance_min_max.sv]
// The shared subtractor runs three 64-step restoring divisions, each with a rounding
// step, then a SAMPLE_BITS-step square root; the first sample of a stream goes
// straight to the square root. One sample is in flight at a time; the next can be
// taken in the cycle after the result is loaded into the output register.
// Asynchronous active-low reset clears statistics (min/max to extreme codes) and control.
`timescale 1ns / 1ps
`include "running_mean_variance_min_max_macros.svh"
module running_mean_variance_min_max #(
	parameter int SAMPLE_BITS = 24,
	parameter int COUNT_BITS  = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	rmvmm_in_if.sink     item,
	rmvmm_out_if.source  result
);
	localparam int S     = SAMPLE_BITS;
	localparam int CB    = COUNT_BITS;
	localparam int MX    = rmvmm_pkg::MEAN_EXTRA;
	localparam int MW    = S + MX;
	localparam int DW    = rmvmm_pkg::DIV_W;
	localparam int ITW   = rmvmm_pkg::IT_W;
	localparam int ALU_W = (CB + 1 > S + 3) ? CB + 1 : S + 3;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SETUP = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_RND   = 3'd4;
	localparam logic [2:0] ST_SQSET = 3'd5;
	localparam logic [2:0] ST_SQRT  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam logic [1:0] OP_MEAN = 2'd0;
	localparam logic [1:0] OP_VAR  = 2'd1;
	localparam logic [1:0] OP_SQ   = 2'd2;

	localparam logic signed [S-1:0] MAX_CODE = {1'b0, {(S-1){1'b1}}};
	localparam logic signed [S-1:0] MIN_CODE = {1'b1, {(S-1){1'b0}}};

	logic [2:0]             state_q;
	logic [1:0]             op_q;
	logic signed [S-1:0]    x_q;
	logic                   new_q;
	logic [CB-1:0]          count_q;
	logic signed [MW-1:0]   mean_q;
	logic [DW-1:0]          var_q;
	logic signed [S-1:0]    min_q;
	logic signed [S-1:0]    max_q;
	logic                   neg_q;
	logic [S:0]             dmag_q;
	logic [DW-1:0]          sq_q;
	logic [DW-1:0]          keep_q;
	logic [DW-1:0]          dvd_q;
	logic [ALU_W-1:0]       rem_q;
	logic [CB-1:0]          dvs_q;
	logic [ITW-1:0]         it_q;
	logic [S-1:0]           root_q;
	logic [2*S-1:0]         vout_q;
	logic                   rv_q;

	logic [CB-1:0]          cnt_base;
	logic [CB-1:0]          n_next;
	logic signed [S-1:0]    min_base;
	logic signed [S-1:0]    max_base;
	logic signed [MW-1:0]   xe;
	logic signed [S-1:0]    old_s;
	logic [MW:0]            mdiff;
	logic [MW:0]            mmag;
	logic [S:0]             dd;
	logic [S:0]             dmag;
	logic [2*S+1:0]         prod;
	logic [ALU_W-1:0]       alu_a;
	logic [ALU_W-1:0]       alu_b;
	logic [ALU_W-1:0]       alu_diff;
	logic                   alu_ge;
	logic                   rnd_up;
	logic [DW-1:0]          q_rnd;
	logic [DW:0]            vsum;
	logic [2*S-1:0]         vout;
	logic                   out_free;

	function automatic logic signed [S-1:0] to_sample(input logic signed [MW-1:0] m);
		logic [MW:0] r;
		r = {m[MW-1], m} + (MW+1)'(rmvmm_pkg::MEAN_HALF);
		return r[MX +: S];
	endfunction

	assign item.ready = (state_q == ST_IDLE);
	assign out_free   = ~rv_q | result.ready;

	// setup arithmetic on the accepted sample
	always_comb begin
		cnt_base = new_q ? '0 : count_q;
		n_next   = (&cnt_base) ? cnt_base : cnt_base + 1'b1;
		min_base = new_q ? MAX_CODE : min_q;
		max_base = new_q ? MIN_CODE : max_q;
		xe       = {x_q, {MX{1'b0}}};
		old_s    = to_sample(mean_q);
		mdiff    = {xe[MW-1], xe} - {mean_q[MW-1], mean_q};
		mmag     = mdiff[MW] ? -mdiff : mdiff;
		dd       = {x_q[S-1], x_q} - {old_s[S-1], old_s};
		dmag     = dd[S] ? -dd : dd;
		prod     = dmag_q * dmag_q;
	end

	always_comb begin
		unique case (state_q)
			ST_DIV: begin
				alu_a = ALU_W'({rem_q[CB-1:0], dvd_q[DW-1]});
				alu_b = ALU_W'(dvs_q);
			end
			ST_RND: begin
				alu_a = ALU_W'({rem_q[CB-1:0], 1'b0});
				alu_b = ALU_W'(dvs_q);
			end
			ST_SQRT: begin
				alu_a = ALU_W'({rem_q[S:0], dvd_q[DW-1:DW-2]});
				alu_b = ALU_W'({root_q, 2'b01});
			end
			default: begin
				alu_a = '0;
				alu_b = '0;
			end
		endcase
	end

	rmvmm_alu #(.W(ALU_W)) u_alu (
		.a    (alu_a),
		.b    (alu_b),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	// round half up: remainder at least half the divisor
	always_comb begin
		rnd_up = alu_ge & (rem_q[CB-1:0] != '0);
		q_rnd  = dvd_q + DW'(rnd_up);
		vsum   = {1'b0, keep_q} + {1'b0, q_rnd};
		vout   = ((var_q >> (2*S)) != '0) ? {(2*S){1'b1}} : var_q[2*S-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_MEAN;
			count_q <= '0;
			mean_q  <= '0;
			var_q   <= '0;
			min_q   <= MAX_CODE;
			max_q   <= MIN_CODE;
			rv_q    <= 1'b0;
			it_q    <= '0;
		end else begin
			if (state_q == ST_DONE && out_free)
				rv_q <= 1'b1;
			else if (result.ready)
				rv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (item.valid)
						state_q <= ST_SETUP;
				end
				ST_SETUP: begin
					count_q <= n_next;
					min_q   <= (x_q < min_base) ? x_q : min_base;
					max_q   <= (x_q > max_base) ? x_q : max_base;
					if (n_next == CB'(1)) begin
						mean_q  <= xe;
						var_q   <= '0;
						state_q <= ST_SQSET;
					end else begin
						op_q    <= OP_MEAN;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					it_q    <= ITW'(DW - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					it_q <= it_q - 1'b1;
					if (it_q == '0)
						state_q <= ST_RND;
				end
				ST_RND: begin
					it_q <= ITW'(DW - 1);
					case (op_q)
						OP_MEAN: begin
							mean_q  <= neg_q ? mean_q - MW'(q_rnd) : mean_q + MW'(q_rnd);
							op_q    <= OP_VAR;
							state_q <= ST_DIV;
						end
						OP_VAR: begin
							op_q    <= OP_SQ;
							state_q <= ST_DIV;
						end
						default: begin
							var_q   <= vsum[DW] ? {DW{1'b1}} : vsum[DW-1:0];
							state_q <= ST_SQSET;
						end
					endcase
				end
				ST_SQSET: begin
					it_q    <= ITW'(S - 1);
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					it_q <= it_q - 1'b1;
					if (it_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item.valid) begin
					x_q   <= item.sample;
					new_q <= item.new_stream;
				end
			end
			ST_SETUP: begin
				neg_q  <= mdiff[MW];
				dmag_q <= dmag;
				dvd_q  <= DW'(mmag);
				dvs_q  <= n_next;
				rem_q  <= '0;
			end
			ST_MUL: begin
				sq_q <= DW'(prod);
			end
			ST_DIV: begin
				rem_q <= alu_ge ? alu_diff : alu_a;
				dvd_q <= {dvd_q[DW-2:0], alu_ge};
			end
			ST_RND: begin
				rem_q <= '0;
				case (op_q)
					OP_MEAN: begin
						dvd_q <= var_q;
						dvs_q <= count_q - 1'b1;
					end
					OP_VAR: begin
						keep_q <= var_q - q_rnd;
						dvd_q  <= sq_q;
						dvs_q  <= count_q;
					end
					default: ;
				endcase
			end
			ST_SQSET: begin
				vout_q <= vout;
				dvd_q  <= DW'(vout) << (DW - 2*S);
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQRT: begin
				rem_q  <= alu_ge ? alu_diff : alu_a;
				root_q <= {root_q[S-2:0], alu_ge};
				dvd_q  <= {dvd_q[DW-3:0], 2'b00};
			end
			ST_DONE: begin
				if (out_free) begin
					result.sample_count    <= count_q;
					result.mean_value      <= to_sample(mean_q);
					result.variance        <= vout_q;
					result.std_deviation   <= root_q;
					result.minimum         <= min_q;
					result.maximum         <= max_q;
					result.count_saturated <= &count_q;
				end
			end
			default: ;
		endcase
	end

	assign result.valid = rv_q;

	`RMV_ASSERT_NXT(a_accept_setup, item.valid && item.ready, state_q == ST_SETUP)
	`RMV_ASSERT_IMP(a_div_nonzero, state_q == ST_DIV, dvs_q != '0)
	`RMV_ASSERT_NXT(a_count_nonzero, state_q == ST_SETUP, count_q != '0)
	`RMV_ASSERT_NXT(a_done_holds, state_q == ST_DONE && rv_q && !result.ready, state_q == ST_DONE)
	`RMV_ASSERT_NXT(a_mean_then_var, state_q == ST_RND && op_q == OP_MEAN, op_q == OP_VAR)
endmodule

[verif/running_mean_variance_min_max_checker.sv]
// Checker for the running statistics block: predicts each result and compares it.
`timescale 1ns / 1ps
module running_mean_variance_min_max_checker (
	input  logic  clk,
	input  logic  arst_n,
	rmvmm_in_if   item,
	rmvmm_out_if  result,
	output int    errors,
	output int    pending
);
	typedef struct packed {
		logic [31:0] count;
		logic [23:0] mean;
		logic [47:0] var_q;
		logic [23:0] stdev;
		logic [23:0] min_v;
		logic [23:0] max_v;
		logic        sat;
	} stats_t;

	localparam longint SMAX = 64'sd8388607;
	localparam logic [63:0] CMAX = 64'hFFFF_FFFF;

	logic [63:0]    n_acc;
	longint         mean_acc;
	logic [63:0]    var_acc;
	longint         min_acc, max_acc;
	stats_t         stats_q[$];

	function automatic logic [63:0] div_near(logic [63:0] a, logic [63:0] m);
		logic [63:0] q, r;
		q = a / m;
		r = a % m;
		if (r != 0 && r >= m - r)
			q++;
		return q;
	endfunction

	function automatic longint to_sample(longint m);
		longint a;
		logic [63:0] u;
		a = m + rmvmm_pkg::MEAN_HALF;
		if (a >= 0)
			return a >>> rmvmm_pkg::MEAN_EXTRA;
		u = -a;
		return -longint'((u + ((64'd1 << rmvmm_pkg::MEAN_EXTRA) - 1)) >> rmvmm_pkg::MEAN_EXTRA);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic clear_stats();
		n_acc = 0;
		mean_acc = 0;
		var_acc = 0;
		min_acc = SMAX;
		max_acc = -SMAX - 1;
	endtask

	task automatic include_sample(logic signed [23:0] s, logic fresh);
		longint x, old_s, diff, d;
		logic [63:0] mag, keep, add, vo;
		stats_t e;
		x = longint'(s);
		if (fresh)
			clear_stats();
		if (n_acc < CMAX)
			n_acc++;
		old_s = to_sample(mean_acc);
		if (n_acc == 1) begin
			mean_acc = x <<< rmvmm_pkg::MEAN_EXTRA;
			var_acc = 0;
		end else begin
			diff = (x <<< rmvmm_pkg::MEAN_EXTRA) - mean_acc;
			if (diff >= 0)
				mean_acc += longint'(div_near(diff, n_acc));
			else
				mean_acc -= longint'(div_near(-diff, n_acc));
			d = x - old_s;
			mag = d >= 0 ? d : -d;
			keep = var_acc - div_near(var_acc, n_acc - 1);
			add = div_near(mag * mag, n_acc);
			var_acc = (keep > ~64'd0 - add) ? ~64'd0 : keep + add;
		end
		if (x < min_acc)
			min_acc = x;
		if (x > max_acc)
			max_acc = x;
		vo = var_acc > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : var_acc;
		e.count = n_acc[31:0];
		e.mean = 24'(to_sample(mean_acc));
		e.var_q = vo[47:0];
		e.stdev = 24'(root_floor(vo));
		e.min_v = 24'(min_acc);
		e.max_v = 24'(max_acc);
		e.sat = n_acc == CMAX;
		stats_q.push_back(e);
	endtask

	assign pending = stats_q.size();

	always @(posedge clk or negedge arst_n) begin
		stats_t e, got;
		if (!arst_n) begin
			clear_stats();
			stats_q.delete();
			errors <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got = '{result.sample_count, result.mean_value, result.variance,
					result.std_deviation, result.minimum, result.maximum,
					result.count_saturated};
				if (stats_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					e = stats_q.pop_front();
					if (got !== e) begin
						$display({"%0t: mismatch expected cnt %0d mean %h var %h",
							" sd %h min %h max %h sat %b"},
							$time, e.count, e.mean, e.var_q, e.stdev, e.min_v,
							e.max_v, e.sat);
						$display({"%0t:            actual cnt %0d mean %h var %h",
							" sd %h min %h max %h sat %b"},
							$time, got.count, got.mean, got.var_q, got.stdev,
							got.min_v, got.max_v, got.sat);
						errors <= errors + 1;
					end
				end
			end
			// one in flight: predict after checking the older result
			if (item.valid && item.ready)
				include_sample(item.sample, item.new_stream);
		end
	end
endmodule

[verif/running_mean_variance_min_max_tb.sv]
// Testbench top: drives samples with random idling, stalls the receiver at random and reports the verdict.
`timescale 1ns / 1ps
module running_mean_variance_min_max_tb;
	logic clk;
	logic arst_n;
	int   errors, pending;
	int   idle_pct, stall_pct;
	int   quiet = 0;

	rmvmm_in_if  item_ch();
	rmvmm_out_if result_ch();

	running_mean_variance_min_max dut (
		.clk(clk), .arst_n(arst_n), .item(item_ch.sink), .result(result_ch.source)
	);

	running_mean_variance_min_max_checker chk (
		.clk(clk), .arst_n(arst_n), .item(item_ch), .result(result_ch),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 0;
		else
			result_ch.ready <= $urandom_range(99) >= stall_pct;
	end

	// watchdog on transactions
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send(logic signed [23:0] s, logic fresh);
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 0;
			@(posedge clk);
		end
		item_ch.valid <= 1;
		item_ch.sample <= s;
		item_ch.new_stream <= fresh;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
	endtask

	task automatic random_stream(int len);
		int mode;
		logic signed [23:0] s, base;
		mode = $urandom_range(3);
		base = 24'($urandom);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: s = 24'($urandom);
				1: s = base + $signed(24'($urandom_range(511))) - 24'sd256;
				2: s = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
				default: s = $signed(24'($urandom_range(4095))) - 24'sd2048;
			endcase
			send(s, i == 0);
		end
	endtask

	initial begin
		idle_pct = 0;
		stall_pct = 0;
		item_ch.valid = 0;
		item_ch.sample = 0;
		item_ch.new_stream = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, single sample, constant stream, alternating extremes
		send(24'sh7FFFFF, 0);
		send(24'sh800000, 0);
		send(24'sh800000, 0);
		send(24'sh7FFFFF, 0);
		send(24'sh000000, 1);
		send(24'sh000000, 0);
		send(24'sh000100, 1);
		send(24'sh000100, 0);
		send(24'sh000100, 0);
		send(-24'sh000001, 1);
		send(24'sh000001, 0);
		send(-24'sh000001, 0);
		send(24'sh7FFFFF, 1);
		for (int i = 0; i < 8; i++)
			send(i[0] ? 24'sh7FFFFF : 24'sh800000, 0);
		send(24'sh555555, 1);
		send(24'shAAAAAA, 0);
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 76; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 76; end
				default: begin idle_pct = 12; stall_pct = 12; end
			endcase
			for (int k = 0; k < 200; ) begin
				int len;
				len = $urandom_range(40, 1);
				random_stream(len);
				k += len;
			end
		end
		item_ch.valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
